[rtl/glyph_pixel_write_expander_macros.svh]
// Assertion macros for the glyph pixel write expander.
// Depends on nothing; included by the files that carry assertions.
`ifndef GLYPH_PIXEL_WRITE_EXPANDER_MACROS_SVH
`define GLYPH_PIXEL_WRITE_EXPANDER_MACROS_SVH

`ifndef ASSERT_OFF

// Property checked on every rising clock edge outside reset.
`define GPWE_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed: label");

// Condition that must never be true outside reset.
`define GPWE_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error("forbidden condition: label");

`else

`define GPWE_ASSERT(label, clk, rst_n, prop)
`define GPWE_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

[rtl/gpwe_pkg.sv]
// Shared types and constants of the glyph pixel write expander.
// Depends on nothing; used by the address unit, the sequencer and the top level.
package gpwe_pkg;

	localparam int unsigned ROW_COUNT       = 8;
	localparam int unsigned COL_COUNT       = 8;
	localparam int unsigned ROW_IDX_W       = 3;
	localparam int unsigned GLYPH_BITS      = ROW_COUNT * COL_COUNT;
	localparam int unsigned BYTES_PER_PIXEL = 3;
	localparam int unsigned ADDR_W          = 32;
	localparam int unsigned COLOR_W         = 24;
	localparam int unsigned CFG_INDEX_W     = 2;
	localparam int unsigned CFG_DATA_W      = 32;
	localparam int unsigned FETCH_CNT_W     = 4;

	localparam logic OP_DRAW = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	localparam logic [CFG_INDEX_W-1:0] REG_TOP_BUF0    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TOP_BUF1    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BOTTOM_BUF0 = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_BOTTOM_BUF1 = 2'd3;

	typedef struct packed {
		logic         op;
		logic [7:0]   char_code;
		logic [2:0]   glyph_row;
		logic [7:0]   row_bits;
		logic [8:0]   pos_x;
		logic [7:0]   pos_y;
		logic [23:0]  color;
		logic         bottom_screen;
		logic         use_other_buffer;
		logic         active_buffer;
	} gpwe_cmd_t;

	typedef struct packed {
		logic [31:0]  write_address;
		logic [23:0]  write_color;
		logic         last_write;
	} gpwe_result_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_SCAN
	} gpwe_state_t;

	typedef enum logic [2:0] {
		AU_HOLD,
		AU_LOAD,
		AU_ADD_PROD,
		AU_ADD_OFF,
		AU_MARK_ROW,
		AU_NEXT_COL,
		AU_NEXT_ROW
	} gpwe_au_op_t;

	typedef struct packed {
		gpwe_au_op_t           au_op;
		logic                  emit;
		logic                  last;
		logic [ROW_IDX_W-1:0]  rd_row;
	} gpwe_ctrl_t;

endpackage

[rtl/gpwe_font_mem.sv]
// Glyph row store: one write port and one registered read port.
// Depends on nothing; instantiated by the top level.
module gpwe_font_mem #(
	parameter int unsigned DEPTH = 2048,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic           clk,
	input  logic           we,
	input  logic [AW-1:0]  waddr,
	input  logic [7:0]     wdata,
	input  logic [AW-1:0]  raddr,
	output logic [7:0]     rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/gpwe_addr_unit.sv]
// Address unit: one shared 32-bit adder that builds and steps the pixel address.
// Depends on gpwe_pkg for the operation codes and pixel constants.
module gpwe_addr_unit #(
	parameter int unsigned SCREEN_LINE_PIXELS = 240
) (
	input  logic                   clk,
	input  gpwe_pkg::gpwe_au_op_t  au_op,
	input  logic [31:0]            base,
	input  logic [8:0]             pos_x,
	input  logic [7:0]             pos_y,
	output logic [31:0]            addr
);

	localparam int unsigned LINE_BYTES = SCREEN_LINE_PIXELS * gpwe_pkg::BYTES_PER_PIXEL;
	localparam int unsigned LB_W       = $clog2(LINE_BYTES + 1);
	localparam int unsigned PROD_W     = 9 + LB_W;
	localparam logic [31:0] COL_STEP   = 32'(LINE_BYTES);
	localparam logic [31:0] ROW_STEP   = ~32'(gpwe_pkg::BYTES_PER_PIXEL) + 32'd1;
	localparam logic [31:0] OFF_BASE   = 32'(LINE_BYTES - gpwe_pkg::BYTES_PER_PIXEL);

	logic [PROD_W-1:0] prod_q;
	logic [31:0]       off_q;
	logic [31:0]       acc_q;
	logic [31:0]       row_q;
	logic [31:0]       opa;
	logic [31:0]       opb;
	logic [31:0]       sum;

	// Operand selection for the shared adder.
	always_comb begin
		opa = (au_op == gpwe_pkg::AU_NEXT_ROW) ? row_q : acc_q;
		unique case (au_op)
			gpwe_pkg::AU_ADD_PROD: opb = 32'(prod_q);
			gpwe_pkg::AU_ADD_OFF:  opb = off_q;
			gpwe_pkg::AU_NEXT_COL: opb = COL_STEP;
			gpwe_pkg::AU_NEXT_ROW: opb = ROW_STEP;
			default:               opb = 32'd0;
		endcase
		sum = opa + opb;
	end

	always_ff @(posedge clk) begin
		unique case (au_op)
			gpwe_pkg::AU_LOAD: begin
				acc_q  <= base;
				prod_q <= PROD_W'(pos_x) * PROD_W'(LINE_BYTES);
				off_q  <= OFF_BASE - ((32'(pos_y) << 1) + 32'(pos_y));
			end
			gpwe_pkg::AU_ADD_PROD,
			gpwe_pkg::AU_ADD_OFF,
			gpwe_pkg::AU_NEXT_COL: begin
				acc_q <= sum;
			end
			gpwe_pkg::AU_MARK_ROW: begin
				row_q <= acc_q;
			end
			gpwe_pkg::AU_NEXT_ROW: begin
				acc_q <= sum;
				row_q <= sum;
			end
			default: begin
			end
		endcase
	end

	assign addr = acc_q;

endmodule

[rtl/gpwe_seq.sv]
// Sequencer: fetches the eight glyph rows, then scans the 64 glyph bits up to the last set one.
// Depends on gpwe_pkg for the state, operation and control types.
module gpwe_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  draw_go,
	input  logic [7:0]            rdata,
	output logic                  busy,
	output gpwe_pkg::gpwe_ctrl_t  ctrl
);

	localparam logic [gpwe_pkg::FETCH_CNT_W-1:0] FETCH_LAST =
		gpwe_pkg::FETCH_CNT_W'(gpwe_pkg::ROW_COUNT);
	localparam logic [gpwe_pkg::ROW_IDX_W-1:0] COL_LAST =
		gpwe_pkg::ROW_IDX_W'(gpwe_pkg::COL_COUNT - 1);

	gpwe_pkg::gpwe_state_t                state_q;
	gpwe_pkg::gpwe_state_t                state_d;
	logic [gpwe_pkg::FETCH_CNT_W-1:0]     cnt_q;
	logic [gpwe_pkg::ROW_IDX_W-1:0]       x_q;
	logic [gpwe_pkg::GLYPH_BITS-1:0]      bits_q;
	logic                                 rest_zero;

	assign rest_zero = (bits_q[gpwe_pkg::GLYPH_BITS-2:0] == '0);
	assign busy      = (state_q != gpwe_pkg::S_IDLE);

	always_comb begin
		unique case (state_q)
			gpwe_pkg::S_IDLE:  state_d = draw_go ? gpwe_pkg::S_FETCH : gpwe_pkg::S_IDLE;
			gpwe_pkg::S_FETCH: state_d = (cnt_q == FETCH_LAST) ? gpwe_pkg::S_SCAN
			                                                   : gpwe_pkg::S_FETCH;
			gpwe_pkg::S_SCAN:  state_d = rest_zero ? gpwe_pkg::S_IDLE : gpwe_pkg::S_SCAN;
			default:           state_d = gpwe_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '{au_op: gpwe_pkg::AU_HOLD, emit: 1'b0, last: 1'b0, rd_row: '0};
		unique case (state_q)
			gpwe_pkg::S_IDLE: begin
				if (draw_go) begin
					ctrl.au_op = gpwe_pkg::AU_LOAD;
				end
			end
			gpwe_pkg::S_FETCH: begin
				ctrl.rd_row = cnt_q[gpwe_pkg::ROW_IDX_W-1:0];
				unique case (cnt_q)
					4'd0:    ctrl.au_op = gpwe_pkg::AU_ADD_PROD;
					4'd1:    ctrl.au_op = gpwe_pkg::AU_ADD_OFF;
					4'd2:    ctrl.au_op = gpwe_pkg::AU_MARK_ROW;
					default: ctrl.au_op = gpwe_pkg::AU_HOLD;
				endcase
			end
			gpwe_pkg::S_SCAN: begin
				ctrl.emit  = bits_q[gpwe_pkg::GLYPH_BITS-1];
				ctrl.last  = rest_zero;
				ctrl.au_op = (x_q == COL_LAST) ? gpwe_pkg::AU_NEXT_ROW
				                               : gpwe_pkg::AU_NEXT_COL;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gpwe_pkg::S_IDLE;
			cnt_q   <= '0;
			x_q     <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_q == gpwe_pkg::S_FETCH) ? cnt_q + 1'b1 : '0;
			x_q     <= (state_q == gpwe_pkg::S_SCAN) ? x_q + 1'b1 : '0;
		end
	end

	// Rows arrive in the cycle after their read; row zero ends up in the top byte.
	always_ff @(posedge clk) begin
		if (state_q == gpwe_pkg::S_FETCH && cnt_q != '0) begin
			bits_q <= {bits_q[gpwe_pkg::GLYPH_BITS-9:0], rdata};
		end else if (state_q == gpwe_pkg::S_SCAN) begin
			bits_q <= {bits_q[gpwe_pkg::GLYPH_BITS-2:0], 1'b0};
		end
	end

endmodule

[rtl/glyph_pixel_write_expander.sv]
// Glyph pixel write expander top level; uses gpwe_pkg, gpwe_font_mem,
// gpwe_addr_unit, gpwe_seq and glyph_pixel_write_expander_macros.svh.
// A load beat leaves busy low. A draw beat holds busy while the sequencer fetches the
// eight glyph rows and scans the glyph bits in row-major order up to the last set one.
// Each result strobe comes in the cycle after its scan step; the receiver cannot stall.
// arst_n clears the sequencer, the strobe and the base registers; the font store keeps its data.
`include "glyph_pixel_write_expander_macros.svh"

module glyph_pixel_write_expander #(
	parameter int unsigned SCREEN_LINE_PIXELS = 240,
	parameter int unsigned GLYPH_COUNT        = 256
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  gpwe_pkg::gpwe_cmd_t                   cmd,
	output logic                                  result_strobe,
	output gpwe_pkg::gpwe_result_t                result,
	input  logic                                  cfg_we,
	input  logic [gpwe_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [gpwe_pkg::CFG_DATA_W-1:0]       cfg_data
);

	// The font store holds eight rows for each glyph; a row address is the
	// glyph code with the row index appended below it.
	localparam int unsigned GLYPH_DEPTH = GLYPH_COUNT * gpwe_pkg::ROW_COUNT;
	localparam int unsigned MEM_AW      = $clog2(GLYPH_DEPTH);
	localparam int unsigned CODE_W      = MEM_AW - gpwe_pkg::ROW_IDX_W;

	logic [31:0]               base_q [4];
	logic [31:0]               base_sel;
	logic                      accept;
	logic                      code_ok;
	logic                      draw_go;
	logic                      load_we;
	logic [CODE_W-1:0]         code_q;
	logic [23:0]               color_q;
	logic [7:0]                rdata;
	logic [MEM_AW-1:0]         raddr;
	logic [MEM_AW-1:0]         waddr;
	logic [31:0]               addr;
	gpwe_pkg::gpwe_ctrl_t      ctrl;
	logic                      result_strobe_q;
	gpwe_pkg::gpwe_result_t    result_q;

	// A beat is taken whenever the sequencer is idle. Codes past the end of
	// the font are dropped: a draw of one starts nothing and a load writes nothing.
	assign accept  = start && !busy;
	assign code_ok = (9'(cmd.char_code) < 9'(GLYPH_COUNT));
	assign draw_go = accept && (cmd.op == gpwe_pkg::OP_DRAW) && code_ok;
	assign load_we = accept && (cmd.op == gpwe_pkg::OP_LOAD) && code_ok;

	// The framebuffer is picked by screen, then by the displayed buffer
	// flipped when the other buffer is asked for.
	assign base_sel = base_q[{cmd.bottom_screen, cmd.active_buffer ^ cmd.use_other_buffer}];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				base_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				gpwe_pkg::REG_TOP_BUF0:    base_q[0] <= cfg_data;
				gpwe_pkg::REG_TOP_BUF1:    base_q[1] <= cfg_data;
				gpwe_pkg::REG_BOTTOM_BUF0: base_q[2] <= cfg_data;
				gpwe_pkg::REG_BOTTOM_BUF1: base_q[3] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The glyph code and color are held for the whole draw.
	always_ff @(posedge clk) begin
		if (draw_go) begin
			code_q  <= cmd.char_code[CODE_W-1:0];
			color_q <= cmd.color;
		end
	end

	assign waddr = {cmd.char_code[CODE_W-1:0], cmd.glyph_row};
	assign raddr = {code_q, ctrl.rd_row};

	gpwe_font_mem #(
		.DEPTH(GLYPH_DEPTH)
	) u_font_mem (
		.clk   (clk),
		.we    (load_we),
		.waddr (waddr),
		.wdata (cmd.row_bits),
		.raddr (raddr),
		.rdata (rdata)
	);

	// The address unit gets the base and position straight from the draw
	// beat; its first step, taken at the accept edge, loads them.
	gpwe_addr_unit #(
		.SCREEN_LINE_PIXELS(SCREEN_LINE_PIXELS)
	) u_addr_unit (
		.clk   (clk),
		.au_op (ctrl.au_op),
		.base  (base_sel),
		.pos_x (cmd.pos_x),
		.pos_y (cmd.pos_y),
		.addr  (addr)
	);

	gpwe_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.draw_go (draw_go),
		.rdata   (rdata),
		.busy    (busy),
		.ctrl    (ctrl)
	);

	// Each set glyph bit found by the scan is registered here and shown for
	// exactly one cycle. The scan step that sees no set bit further on marks
	// its write as the last one of the character.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe_q <= 1'b0;
		end else begin
			result_strobe_q <= ctrl.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			result_q.write_address <= addr;
			result_q.write_color   <= color_q;
			result_q.last_write    <= ctrl.last;
		end
	end

	assign result_strobe = result_strobe_q;
	assign result        = result_q;

	// A result is only ever produced by a scan step of a running draw.
	`GPWE_ASSERT(a_strobe_after_busy, clk, arst_n, result_strobe |-> $past(busy))

	// A draw with a valid code always starts the sequencer.
	`GPWE_ASSERT(a_draw_starts, clk, arst_n, draw_go |=> busy)

	// The final write of a character leaves the sequencer idle.
	`GPWE_ASSERT_NEVER(a_last_while_busy, clk, arst_n, result_strobe && result.last_write && busy)

endmodule
